/* src/lhp_pkg.sv */
`timescale 1ns / 1ps

package lhp_pkg;

  localparam int CFG_W       = 11;
  localparam int SEEN_W      = 21;
  localparam int WIDTH_RESET = 500;
  localparam int WIDTH_MIN   = 3;

  typedef struct packed {
    logic [7:0] red;
    logic [7:0] green;
    logic [7:0] blue;
    logic       frame_end;
  } pix_t;

  typedef struct packed {
    logic [7:0] filtered_pixel;
    logic       last_out;
  } res_t;

  // Which results the registered window produces.
  typedef struct packed {
    logic norm;
    logic fin;
    logic fin_ok;
  } win_ctl_t;

  // Gray taps by age behind the newest pixel (a0 is the newest).
  typedef struct packed {
    logic [7:0] a0;
    logic [7:0] wm2;
    logic [7:0] wm1;
    logic [7:0] w0;
    logic [7:0] wp1;
    logic [7:0] w2m1;
    logic [7:0] w2;
  } win_taps_t;

  // (r+g+b)/3 as a multiply by 683/2048; exact for sums up to 765.
  function automatic logic [7:0] gray_of(input logic [7:0] r, input logic [7:0] g,
                                         input logic [7:0] b);
    logic [9:0]  s;
    logic [19:0] p;
    s = 10'(r) + 10'(g) + 10'(b);
    p = 20'(s) * 20'd683;
    return p[18:11];
  endfunction

  function automatic logic [7:0] lap_clamp(input logic [7:0] c, input logic [7:0] n1,
                                           input logic [7:0] n2, input logic [7:0] n3,
                                           input logic [7:0] n4);
    logic signed [11:0] sum;
    sum = $signed({2'b00, c, 2'b00} - {4'b0000, n1} - {4'b0000, n2}
                  - {4'b0000, n3} - {4'b0000, n4});
    if (sum < 0) begin
      return 8'd0;
    end else if (sum > 12'sd255) begin
      return 8'hFF;
    end else begin
      return sum[7:0];
    end
  endfunction

endpackage

/* src/lhp_hist_ram.sv */
`timescale 1ns / 1ps

module lhp_hist_ram #(
  parameter int DEPTH = 2050,
  parameter int AW    = 12
) (
  input  logic          clk,
  input  logic          we,
  input  logic [AW-1:0] waddr,
  input  logic [7:0]    wdata,
  input  logic          re,
  input  logic [AW-1:0] raddr_a,
  input  logic [AW-1:0] raddr_b,
  output logic [7:0]    rdata_a,
  output logic [7:0]    rdata_b
);

  logic [7:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
  end

  always_ff @(posedge clk) begin
    if (re) begin
      rdata_a <= mem[raddr_a];
      rdata_b <= mem[raddr_b];
    end
  end

endmodule

/* src/lhp_taps.sv */
`timescale 1ns / 1ps

module lhp_taps import lhp_pkg::*; #(
  parameter int MAX_WIDTH = 1024
) (
  input  logic             clk,
  input  logic             rst,
  input  logic             cfg_we,
  input  logic [CFG_W-1:0] cfg_wdata,
  input  logic             pix_valid,
  output logic             pix_ready,
  input  pix_t             pix,
  output logic             win_valid,
  output win_ctl_t         win_ctl,
  output win_taps_t        win_taps,
  input  logic             win_take
);

  localparam int DEPTH = 2 * MAX_WIDTH + 2;
  localparam int AW    = $clog2(DEPTH);
  localparam int WW    = $clog2(MAX_WIDTH + 1);
  localparam int RST_W = (WIDTH_RESET > MAX_WIDTH) ? MAX_WIDTH : WIDTH_RESET;

  logic [WW-1:0]     width;
  logic [SEEN_W-1:0] seen;
  logic [AW-1:0]     wptr;
  logic              accept;
  logic              advance;
  logic [7:0]        gray;
  logic [AW-1:0]     age_w;
  logic [AW-1:0]     age_2w;
  logic [SEEN_W-1:0] seen_inc;
  logic [SEEN_W-1:0] seen_w;
  win_ctl_t          ctl_next;
  logic [AW-1:0]     ad_wm2, ad_wm1, ad_w0, ad_wp1, ad_w2m1, ad_w2;
  logic [7:0]        newest;
  logic [7:0]        rd_wm2, rd_wm1, rd_w0, rd_wp1, rd_w2m1, rd_w2;

  function automatic logic [AW-1:0] back(input logic [AW-1:0] ptr, input logic [AW-1:0] age);
    logic [AW:0] d;
    if (ptr >= age) begin
      d = {1'b0, ptr} - {1'b0, age};
    end else begin
      d = {1'b0, ptr} + (AW + 1)'(DEPTH) - {1'b0, age};
    end
    return d[AW-1:0];
  endfunction

  assign advance   = !win_valid || win_take;
  assign pix_ready = advance;
  assign accept    = pix_valid && advance;
  assign gray      = gray_of(pix.red, pix.green, pix.blue);

  assign age_w  = AW'(width);
  assign age_2w = age_w + age_w;

  // Addresses are taken behind the slot written in this cycle, which is age zero.
  assign ad_wm2  = back(wptr, age_w - AW'(2));
  assign ad_wm1  = back(wptr, age_w - AW'(1));
  assign ad_w0   = back(wptr, age_w);
  assign ad_wp1  = back(wptr, age_w + AW'(1));
  assign ad_w2m1 = back(wptr, age_2w - AW'(1));
  assign ad_w2   = back(wptr, age_2w);

  assign seen_inc = (seen == '1) ? seen : seen + SEEN_W'(1);
  assign seen_w   = SEEN_W'(width);

  always_comb begin
    ctl_next.norm   = seen_inc >= (seen_w + seen_w + SEEN_W'(2));
    ctl_next.fin    = pix.frame_end;
    ctl_next.fin_ok = seen_inc >= (seen_w + seen_w + SEEN_W'(1));
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      width <= WW'(RST_W);
    end else if (cfg_we) begin
      if (cfg_wdata < CFG_W'(WIDTH_MIN)) begin
        width <= WW'(WIDTH_MIN);
      end else if (32'(cfg_wdata) > MAX_WIDTH) begin
        width <= WW'(MAX_WIDTH);
      end else begin
        width <= WW'(cfg_wdata);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      seen <= '0;
      wptr <= '0;
    end else if (accept) begin
      if (pix.frame_end) begin
        seen <= '0;
        wptr <= '0;
      end else begin
        seen <= seen_inc;
        wptr <= (wptr == AW'(DEPTH - 1)) ? '0 : wptr + AW'(1);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      win_valid <= 1'b0;
    end else if (advance) begin
      win_valid <= accept;
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      win_ctl <= ctl_next;
      newest  <= gray;
    end
  end

  assign win_taps = {newest, rd_wm2, rd_wm1, rd_w0, rd_wp1, rd_w2m1, rd_w2};

  lhp_hist_ram #(.DEPTH(DEPTH), .AW(AW)) u_ram_near (
    .clk     (clk),
    .we      (accept),
    .waddr   (wptr),
    .wdata   (gray),
    .re      (accept),
    .raddr_a (ad_wm1),
    .raddr_b (ad_wp1),
    .rdata_a (rd_wm1),
    .rdata_b (rd_wp1)
  );

  lhp_hist_ram #(.DEPTH(DEPTH), .AW(AW)) u_ram_mid (
    .clk     (clk),
    .we      (accept),
    .waddr   (wptr),
    .wdata   (gray),
    .re      (accept),
    .raddr_a (ad_w0),
    .raddr_b (ad_wm2),
    .rdata_a (rd_w0),
    .rdata_b (rd_wm2)
  );

  lhp_hist_ram #(.DEPTH(DEPTH), .AW(AW)) u_ram_far (
    .clk     (clk),
    .we      (accept),
    .waddr   (wptr),
    .wdata   (gray),
    .re      (accept),
    .raddr_a (ad_w2),
    .raddr_b (ad_w2m1),
    .rdata_a (rd_w2),
    .rdata_b (rd_w2m1)
  );

endmodule

/* src/lhp_kernel.sv */
`timescale 1ns / 1ps

module lhp_kernel import lhp_pkg::*; (
  input  logic      win_valid,
  input  win_ctl_t  win_ctl,
  input  win_taps_t win_taps,
  input  logic      win_take,
  output logic      push0,
  output res_t      data0,
  output logic      push1,
  output res_t      data1
);

  logic [7:0] norm_val;
  logic [7:0] fin_val;
  res_t       fin_res;
  logic       fire;

  assign norm_val = lap_clamp(win_taps.w0, win_taps.w2, win_taps.wp1, win_taps.wm1,
                              win_taps.a0);
  // The final window sits one position later, with the missing next pixel as zero.
  assign fin_val  = lap_clamp(win_taps.wm1, win_taps.w2m1, win_taps.w0, win_taps.wm2,
                              8'd0);

  assign fire = win_valid && win_take;

  always_comb begin
    fin_res.filtered_pixel = win_ctl.fin_ok ? fin_val : 8'd0;
    fin_res.last_out       = 1'b1;
    push0 = fire && (win_ctl.norm || win_ctl.fin);
    push1 = fire && win_ctl.norm && win_ctl.fin;
    if (win_ctl.norm) begin
      data0.filtered_pixel = norm_val;
      data0.last_out       = 1'b0;
    end else begin
      data0 = fin_res;
    end
    data1 = fin_res;
  end

endmodule

/* src/lhp_out_fifo.sv */
`timescale 1ns / 1ps

module lhp_out_fifo import lhp_pkg::*; (
  input  logic clk,
  input  logic rst,
  input  logic push0,
  input  res_t data0,
  input  logic push1,
  input  res_t data1,
  output logic free2,
  output logic res_valid,
  input  logic res_ready,
  output res_t res
);

  res_t       q [4];
  logic [1:0] wp;
  logic [1:0] rp;
  logic [2:0] cnt;
  logic       pop;
  logic [2:0] cnt_next;

  assign free2     = cnt <= 3'd2;
  assign res_valid = cnt != 3'd0;
  assign res       = q[rp];
  assign pop       = res_valid && res_ready;

  always_comb begin
    cnt_next = cnt + 3'(push0) + 3'(push1) - 3'(pop);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wp  <= '0;
      rp  <= '0;
      cnt <= '0;
    end else begin
      cnt <= cnt_next;
      if (pop) begin
        rp <= rp + 2'd1;
      end
      if (push1) begin
        wp <= wp + 2'd2;
      end else if (push0) begin
        wp <= wp + 2'd1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (push0) begin
      q[wp] <= data0;
    end
    if (push1) begin
      q[wp + 2'd1] <= data1;
    end
  end

endmodule

/* src/laplacian_highpass_3x3.sv */
`timescale 1ns / 1ps
// A result passes the registered tap window, then the output queue, on its way out.
// Throughput: one pixel per clock unless stalled; tap memories are read once per pixel.
// The frame's last pixel can yield two results, which drain through a four-entry
// output queue; input stalls only while that queue holds three or more results.
// Reset clears the pixel count, write pointer and queue; the width returns to 500.
module laplacian_highpass_3x3 import lhp_pkg::*; #(
  parameter int MAX_WIDTH = 1024
) (
  input  logic             clk,
  input  logic             rst,
  input  logic             cfg_we,
  input  logic [CFG_W-1:0] cfg_wdata,
  input  logic             pix_valid,
  output logic             pix_ready,
  input  pix_t             pix,
  output logic             res_valid,
  input  logic             res_ready,
  output res_t             res
);

  logic      win_valid;
  win_ctl_t  win_ctl;
  win_taps_t win_taps;
  logic      free2;
  logic      push0;
  logic      push1;
  res_t      data0;
  res_t      data1;

  lhp_taps #(.MAX_WIDTH(MAX_WIDTH)) u_taps (
    .clk       (clk),
    .rst       (rst),
    .cfg_we    (cfg_we),
    .cfg_wdata (cfg_wdata),
    .pix_valid (pix_valid),
    .pix_ready (pix_ready),
    .pix       (pix),
    .win_valid (win_valid),
    .win_ctl   (win_ctl),
    .win_taps  (win_taps),
    .win_take  (free2)
  );

  lhp_kernel u_kernel (
    .win_valid (win_valid),
    .win_ctl   (win_ctl),
    .win_taps  (win_taps),
    .win_take  (free2),
    .push0     (push0),
    .data0     (data0),
    .push1     (push1),
    .data1     (data1)
  );

  lhp_out_fifo u_out (
    .clk       (clk),
    .rst       (rst),
    .push0     (push0),
    .data0     (data0),
    .push1     (push1),
    .data1     (data1),
    .free2     (free2),
    .res_valid (res_valid),
    .res_ready (res_ready),
    .res       (res)
  );

endmodule

/* verif/tb.sv */
`timescale 1ns / 1ps

module tb;
  import lhp_pkg::*;

  localparam int MAX_WIDTH      = 1024;
  localparam int HIST_DEPTH     = 2 * MAX_WIDTH + 2;
  localparam int SEEN_MAX       = (1 << SEEN_W) - 1;
  localparam int SETTLE_CYCLES  = 8;
  localparam int WATCHDOG_LIMIT = 2000;
  localparam int IDLE_PCT       = 23;

  logic             clk = 1'b0;
  logic             rst = 1'b1;
  logic             cfg_we = 1'b0;
  logic [CFG_W-1:0] cfg_wdata = '0;
  logic             pix_valid = 1'b0;
  logic             pix_ready;
  pix_t             pix = '0;
  logic             res_valid;
  logic             res_ready = 1'b0;
  res_t             res;

  laplacian_highpass_3x3 #(.MAX_WIDTH(MAX_WIDTH)) u_top (
    .clk      (clk),
    .rst      (rst),
    .cfg_we   (cfg_we),
    .cfg_wdata(cfg_wdata),
    .pix_valid(pix_valid),
    .pix_ready(pix_ready),
    .pix      (pix),
    .res_valid(res_valid),
    .res_ready(res_ready),
    .res      (res)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // Filter state as the block should hold it.
  logic [7:0]       gray_line [HIST_DEPTH];
  int               frame_pixels = 0;
  int               line_ptr = 0;
  logic [CFG_W-1:0] width_reg = CFG_W'(WIDTH_RESET);
  res_t             filt_expected [$];

  bit idle_on = 1'b1;
  int mismatches = 0;
  int results_checked = 0;
  int pixels_sent = 0;
  int frames_sent = 0;
  int width_writes = 0;

  function automatic int eff_width(input logic [CFG_W-1:0] v);
    int w;
    w = int'(v);
    if (w < WIDTH_MIN) w = WIDTH_MIN;
    if (w > MAX_WIDTH) w = MAX_WIDTH;
    return w;
  endfunction

  // Gray value 'age' pixels behind the newest one; negative ages read as zero.
  function automatic int gray_at(input int age);
    int newest;
    if (age < 0) return 0;
    newest = (line_ptr + HIST_DEPTH - 1) % HIST_DEPTH;
    return int'(gray_line[(newest + HIST_DEPTH - (age % HIST_DEPTH)) % HIST_DEPTH]);
  endfunction

  function automatic logic [7:0] laplace_at(input int w, input int shift);
    int sum;
    sum = 4 * gray_at(w - shift) - gray_at(2 * w - shift) - gray_at(w + 1 - shift)
          - gray_at(w - 1 - shift) - gray_at(0 - shift);
    if (sum < 0) sum = 0;
    if (sum > 255) sum = 255;
    return 8'(sum);
  endfunction

  function automatic void predict_filter(input pix_t p);
    int   w;
    res_t r;
    w = eff_width(width_reg);
    gray_line[line_ptr] = 8'((int'(p.red) + int'(p.green) + int'(p.blue)) / 3);
    line_ptr = (line_ptr + 1) % HIST_DEPTH;
    if (frame_pixels < SEEN_MAX) frame_pixels++;
    if (frame_pixels >= 2 * w + 2) begin
      r.filtered_pixel = laplace_at(w, 0);
      r.last_out = 1'b0;
      filt_expected.push_back(r);
    end
    if (p.frame_end) begin
      // A frame too short for any window closes with a single zero result.
      r.filtered_pixel = (frame_pixels >= 2 * w + 1) ? laplace_at(w, 1) : 8'd0;
      r.last_out = 1'b1;
      filt_expected.push_back(r);
      frame_pixels = 0;
      line_ptr = 0;
    end
  endfunction

  function automatic logic [7:0] pick_channel();
    case ($urandom_range(7))
      0: return 8'd0;
      1: return 8'd255;
      default: return 8'($urandom_range(255));
    endcase
  endfunction

  function automatic pix_t rand_pixel(input bit last);
    pix_t p;
    p.red = pick_channel();
    p.green = pick_channel();
    p.blue = pick_channel();
    p.frame_end = last;
    return p;
  endfunction

  function automatic pix_t mk_pix(input logic [7:0] r, input logic [7:0] g,
                                  input logic [7:0] b, input bit last);
    pix_t p;
    p.red = r;
    p.green = g;
    p.blue = b;
    p.frame_end = last;
    return p;
  endfunction

  task automatic send_pixel(input pix_t p);
    @(negedge clk);
    while (idle_on && $urandom_range(99) < IDLE_PCT) begin
      pix_valid = 1'b0;
      @(negedge clk);
    end
    pix_valid = 1'b1;
    pix = p;
    do @(posedge clk); while (!pix_ready);
    predict_filter(p);
    pixels_sent++;
    if (p.frame_end) frames_sent++;
  endtask

  task automatic send_run(input int n, input bit close);
    for (int i = 0; i < n; i++) begin
      send_pixel(rand_pixel(close && i == n - 1));
    end
  endtask

  // Leaves the block with no transaction in flight.
  task automatic wait_drained();
    @(negedge clk);
    pix_valid = 1'b0;
    while (filt_expected.size() > 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  task automatic set_width(input int value);
    wait_drained();
    @(negedge clk);
    cfg_we = 1'b1;
    cfg_wdata = CFG_W'(value);
    width_reg = CFG_W'(value);
    @(negedge clk);
    cfg_we = 1'b0;
    width_writes++;
  endtask

  task automatic test_reset_width();
    // Width 500 after reset, so both frames are too short for a window.
    send_pixel(mk_pix(8'd0, 8'd0, 8'd0, 1'b1));
    send_run(4, 1'b1);
  endtask

  task automatic test_clamp_extremes();
    set_width(3);
    // The first window saturates high, the final one saturates low.
    send_pixel(mk_pix(8'd255, 8'd0, 8'd0, 1'b0));
    send_pixel(mk_pix(8'd0, 8'd0, 8'd0, 1'b0));
    send_pixel(mk_pix(8'd0, 8'd255, 8'd0, 1'b0));
    send_pixel(mk_pix(8'd0, 8'd0, 8'd0, 1'b0));
    send_pixel(mk_pix(8'd255, 8'd255, 8'd255, 1'b0));
    send_pixel(mk_pix(8'd0, 8'd0, 8'd0, 1'b0));
    send_pixel(mk_pix(8'd0, 8'd0, 8'd255, 1'b0));
    send_pixel(mk_pix(8'd0, 8'd0, 8'd0, 1'b1));
    // Exactly 2W+1 pixels: only the final result exists.
    send_run(7, 1'b1);
    send_run(2, 1'b1);
  endtask

  task automatic test_width_range();
    set_width(0);
    send_run(8, 1'b1);
    set_width(1);
    send_run(10, 1'b1);
    set_width(2);
    send_run(7, 1'b1);
    set_width(2047);
    send_run(6, 1'b1);
    set_width(MAX_WIDTH);
    send_run(6, 1'b1);
    set_width(MAX_WIDTH + 1);
    send_run(5, 1'b1);
  endtask

  task automatic test_width_midframe();
    set_width(5);
    send_run(15, 1'b0);
    set_width(4);
    send_run(10, 1'b0);
    set_width(7);
    send_run(12, 1'b1);
  endtask

  task automatic run_random_frames(input int quota);
    int start;
    int ew;
    int len;
    int pick;
    start = pixels_sent;
    while (pixels_sent - start < quota) begin
      if ($urandom_range(1)) begin
        pick = $urandom_range(19);
        if (pick < 17) set_width($urandom_range(3, 10));
        else if (pick < 19) set_width($urandom_range(0, 2));
        else set_width($urandom_range(11, 40));
      end
      ew = eff_width(width_reg);
      if ($urandom_range(4) != 0) len = 2 * ew + 2 + $urandom_range(3 * ew);
      else len = $urandom_range(1, 2 * ew + 1);
      if ($urandom_range(9) == 0 && len > 4) begin
        send_run(len / 2, 1'b0);
        set_width($urandom_range(3, 10));
        send_run(len - len / 2, 1'b1);
      end else begin
        send_run(len, 1'b1);
      end
    end
  endtask

  task automatic test_random_frames();
    idle_on = 1'b1;
    run_random_frames(220);
  endtask

  task automatic test_burst_no_idle();
    idle_on = 1'b0;
    run_random_frames(120);
    idle_on = 1'b1;
  endtask

  always @(negedge clk) begin
    res_ready = idle_on ? ($urandom_range(99) >= IDLE_PCT) : 1'b1;
  end

  always @(posedge clk) begin
    res_t want;
    if (!rst && res_valid && res_ready) begin
      results_checked++;
      if (filt_expected.size() == 0) begin
        mismatches++;
        if (mismatches <= 10)
          $display("unexpected result: pixel=%0d last=%0b", res.filtered_pixel, res.last_out);
      end else begin
        want = filt_expected.pop_front();
        if (res.filtered_pixel !== want.filtered_pixel || res.last_out !== want.last_out) begin
          mismatches++;
          if (mismatches <= 10)
            $display("mismatch at %0t: expected pixel=%0d last=%0b, got pixel=%0d last=%0b",
                     $realtime, want.filtered_pixel, want.last_out,
                     res.filtered_pixel, res.last_out);
        end
      end
    end
  end

  // Ends the run when no transaction has happened on either channel for too long.
  initial begin
    int quiet_cycles;
    quiet_cycles = 0;
    while (quiet_cycles < WATCHDOG_LIMIT) begin
      @(posedge clk);
      if ((pix_valid && pix_ready) || (res_valid && res_ready)) quiet_cycles = 0;
      else quiet_cycles++;
    end
    $display("FAILURE");
    $finish;
  end

  initial begin
    repeat (3) @(negedge clk);
    rst = 1'b0;
    test_reset_width();
    test_clamp_extremes();
    test_width_range();
    test_width_midframe();
    test_random_frames();
    test_burst_no_idle();
    wait_drained();
    $display("Sent %0d pixels in %0d frames over %0d width writes, widths 0 to 2047.",
             pixels_sent, frames_sent, width_writes);
    $display("Checked %0d filter results, %0d mismatches.", results_checked, mismatches);
    if (mismatches == 0) begin
      $display("SUCCESS");
    end else begin
      $display("FAILURE");
    end
    $finish;
  end

endmodule
